// ----- src/handheld_memory_map_unit_macros.svh -----
// Assertion macros of the memory map unit checker.
`ifndef HANDHELD_MEMORY_MAP_UNIT_MACROS_SVH
`define HANDHELD_MEMORY_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HMMU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("memory map unit check failed");

// Next-cycle implication, disabled while reset is high.
`define HMMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("memory map unit check failed");

`endif

// ----- src/hmmu_pkg.sv -----
// Shared types and constants of the memory map unit.
package hmmu_pkg;

   // Store sizes.
   localparam int VIDEO_RAM_BYTES_DEF    = 16384;
   localparam int WORK_RAM_BYTES_DEF     = 32768;
   localparam int SPRITE_TABLE_BYTES_DEF = 160;
   localparam int PALETTE_BYTES_DEF      = 128;

   // Access commands.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Result routes.
   localparam logic [1:0] ROUTE_LOCAL = 2'd0;
   localparam logic [1:0] ROUTE_CART  = 2'd1;
   localparam logic [1:0] ROUTE_SOUND = 2'd2;

   // Copy request kinds.
   localparam logic [1:0] DMA_NONE    = 2'd0;
   localparam logic [1:0] DMA_OAM     = 2'd1;
   localparam logic [1:0] DMA_GENERAL = 2'd2;

   // I/O port offsets inside FF00-FFFF.
   localparam logic [7:0] P_JOYP  = 8'h00;
   localparam logic [7:0] P_SB    = 8'h01;
   localparam logic [7:0] P_DIV   = 8'h04;
   localparam logic [7:0] P_TAC   = 8'h07;
   localparam logic [7:0] P_LCDC  = 8'h40;
   localparam logic [7:0] P_DMA   = 8'h46;
   localparam logic [7:0] P_KEY1  = 8'h4D;
   localparam logic [7:0] P_VBK   = 8'h4F;
   localparam logic [7:0] P_HDMA1 = 8'h51;
   localparam logic [7:0] P_HDMA2 = 8'h52;
   localparam logic [7:0] P_HDMA3 = 8'h53;
   localparam logic [7:0] P_HDMA4 = 8'h54;
   localparam logic [7:0] P_HDMA5 = 8'h55;
   localparam logic [7:0] P_BGPI  = 8'h68;
   localparam logic [7:0] P_BGPD  = 8'h69;
   localparam logic [7:0] P_OBPI  = 8'h6A;
   localparam logic [7:0] P_OBPD  = 8'h6B;
   localparam logic [7:0] P_SVBK  = 8'h70;

   // Fixed addresses and lengths of copy requests.
   localparam logic [15:0] OAM_BASE       = 16'hFE00;
   localparam logic [11:0] OAM_DMA_LENGTH = 12'd160;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } hmmu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } hmmu_status_type;

endpackage

// ----- src/hmmu_ctrl.sv -----
// Controller of the memory map unit: clearing pass, request accept and execute.
module hmmu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  hmmu_pkg::hmmu_status_type status,
   output hmmu_pkg::hmmu_cmd_type    cmd,
   output logic                     busy,
   output logic                     rsp_strobe
);
   import hmmu_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      strobe_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != ST_IDLE);
         strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   assign cmd.clear  = (state_ff == ST_CLEAR);
   assign cmd.accept = (state_ff == ST_IDLE) && start;
   assign cmd.exec   = (state_ff == ST_EXEC);
   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ----- src/hmmu_datapath.sv -----
// Datapath of the memory map unit: stores, port registers and request decode.
module hmmu_datapath #(
   parameter int VIDEO_RAM_BYTES    = hmmu_pkg::VIDEO_RAM_BYTES_DEF,
   parameter int WORK_RAM_BYTES     = hmmu_pkg::WORK_RAM_BYTES_DEF,
   parameter int SPRITE_TABLE_BYTES = hmmu_pkg::SPRITE_TABLE_BYTES_DEF,
   parameter int PALETTE_BYTES      = hmmu_pkg::PALETTE_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hmmu_pkg::hmmu_cmd_type    cmd,
   output hmmu_pkg::hmmu_status_type status,
   input  logic                     req_command,
   input  logic [15:0]              req_address,
   input  logic [7:0]               req_write_data,
   input  logic [7:0]               req_key_state,
   output logic [7:0]               rsp_read_data,
   output logic [1:0]               rsp_route,
   output logic                     rsp_div_reset,
   output logic                     rsp_timer_reset,
   output logic                     rsp_lcd_toggle,
   output logic [1:0]               rsp_dma_kind,
   output logic [15:0]              rsp_dma_source,
   output logic [15:0]              rsp_dma_dest,
   output logic [11:0]              rsp_dma_length
);
   import hmmu_pkg::*;

   localparam int VW  = $clog2(VIDEO_RAM_BYTES);
   localparam int WW  = $clog2(WORK_RAM_BYTES);
   localparam int OW  = $clog2(SPRITE_TABLE_BYTES);
   localparam int PW  = $clog2(PALETTE_BYTES);
   localparam int CW  = WW;
   localparam logic [CW-1:0] CLR_LAST = {CW{1'b1}};

   // Stores.
   logic [7:0] video_mem   [VIDEO_RAM_BYTES];
   logic [7:0] work_mem    [WORK_RAM_BYTES];
   logic [7:0] sprite_mem  [SPRITE_TABLE_BYTES];
   logic [7:0] port_mem    [256];
   logic [7:0] palette_mem [PALETTE_BYTES];

   // Clearing pass counter.
   logic [CW-1:0] clr_cnt_ff;

   // Request registers.
   logic        cmd_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   logic [7:0]  keys_ff;
   logic [VW-1:0] vram_idx_ff;
   logic [WW-1:0] wram_idx_ff;
   logic [OW-1:0] oam_idx_ff;

   // Read data of the stores.
   logic [7:0] vram_q_ff;
   logic [7:0] wram_q_ff;
   logic [7:0] oam_q_ff;
   logic [7:0] port_q_ff;

   // Bank, index and dedicated port registers.
   logic        video_bank_ff, video_bank_in;
   logic [2:0]  work_bank_ff, work_bank_in;
   logic        bg_inc_ff, bg_inc_in;
   logic        ob_inc_ff, ob_inc_in;
   logic        hb_active_ff, hb_active_in;
   logic [15:0] hb_src_ff, hb_src_in;
   logic [15:0] hb_dst_ff, hb_dst_in;
   logic [7:0]  hb_blocks_ff, hb_blocks_in;
   logic [7:0]  joyp_ff, joyp_in;
   logic [7:0]  lcdc_ff, lcdc_in;
   logic [7:0]  hdma1_ff, hdma1_in;
   logic [7:0]  hdma2_ff, hdma2_in;
   logic [7:0]  hdma3_ff, hdma3_in;
   logic [7:0]  hdma4_ff, hdma4_in;
   logic [7:0]  bgpi_ff, bgpi_in;
   logic [7:0]  obpi_ff, obpi_in;

   // Response registers.
   logic [7:0]  rd_ff, rd_in;
   logic [1:0]  route_ff, route_in;
   logic        divr_ff, divr_in;
   logic        timr_ff, timr_in;
   logic        lcdt_ff, lcdt_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] dsrc_ff, dsrc_in;
   logic [15:0] ddst_ff, ddst_in;
   logic [11:0] dlen_ff, dlen_in;

   // Write ports.
   logic          vram_we, wram_we, oam_we, port_we, pal_we;
   logic [7:0]    port_wdata;
   logic [PW-1:0] pal_idx;

   // Decode of the incoming address for the store reads.
   logic          req_oam;
   logic [VW-1:0] req_vram_idx;
   logic [WW-1:0] req_wram_idx;

   assign req_oam      = (req_address >= OAM_BASE) && (req_address <= 16'hFE9F);
   assign req_vram_idx = VW'({video_bank_ff, req_address[12:0]});
   assign req_wram_idx = req_address[12] ? WW'({work_bank_ff, req_address[11:0]})
                                         : WW'({3'b000, req_address[11:0]});

   // Decode of the held address.
   logic is_cart, is_vram, is_wram, is_oam, is_unused, is_sound, is_port;
   logic [7:0] p;
   logic [15:0] hdma_src, hdma_dst;
   logic [7:0]  hdma_blocks;
   logic [5:0]  pal_k;

   assign is_cart   = !addr_ff[15] || (addr_ff[15:13] == 3'b101);
   assign is_vram   = (addr_ff[15:13] == 3'b100);
   assign is_wram   = (addr_ff[15:13] == 3'b110) ||
                      ((addr_ff[15:13] == 3'b111) && (addr_ff < OAM_BASE));
   assign is_oam    = (addr_ff >= OAM_BASE) && (addr_ff <= 16'hFE9F);
   assign is_unused = (addr_ff >= 16'hFEA0) && (addr_ff <= 16'hFEFF);
   assign is_sound  = (addr_ff >= 16'hFF10) && (addr_ff <= 16'hFF3F);
   assign is_port   = (addr_ff[15:8] == 8'hFF) && !is_sound;
   assign p         = addr_ff[7:0];

   assign hdma_src    = {hdma1_ff, hdma2_ff[7:4], 4'h0};
   assign hdma_dst    = {3'b100, hdma3_ff[4:0], hdma4_ff[7:4], 4'h0};
   assign hdma_blocks = {1'b0, data_ff[6:0]} + 8'd1;

   // Execution of the held request.
   always_comb begin
      rd_in        = 8'h00;
      route_in     = ROUTE_LOCAL;
      divr_in      = 1'b0;
      timr_in      = 1'b0;
      lcdt_in      = 1'b0;
      kind_in      = DMA_NONE;
      dsrc_in      = 16'h0000;
      ddst_in      = 16'h0000;
      dlen_in      = 12'h000;
      video_bank_in = video_bank_ff;
      work_bank_in  = work_bank_ff;
      bg_inc_in     = bg_inc_ff;
      ob_inc_in     = ob_inc_ff;
      hb_active_in  = hb_active_ff;
      hb_src_in     = hb_src_ff;
      hb_dst_in     = hb_dst_ff;
      hb_blocks_in  = hb_blocks_ff;
      joyp_in       = joyp_ff;
      lcdc_in       = lcdc_ff;
      hdma1_in      = hdma1_ff;
      hdma2_in      = hdma2_ff;
      hdma3_in      = hdma3_ff;
      hdma4_in      = hdma4_ff;
      bgpi_in       = bgpi_ff;
      obpi_in       = obpi_ff;
      vram_we       = 1'b0;
      wram_we       = 1'b0;
      oam_we        = 1'b0;
      port_we       = 1'b0;
      port_wdata    = data_ff;
      pal_we        = 1'b0;
      pal_idx       = PW'({1'b0, bgpi_ff[5:0]});
      pal_k         = bgpi_ff[5:0];

      if (is_cart) begin
         route_in = ROUTE_CART;
      end else if (is_sound) begin
         route_in = ROUTE_SOUND;
      end else if (is_vram) begin
         vram_we = (cmd_ff == CMD_WRITE);
         if (cmd_ff == CMD_READ) rd_in = vram_q_ff;
      end else if (is_wram) begin
         wram_we = (cmd_ff == CMD_WRITE);
         if (cmd_ff == CMD_READ) rd_in = wram_q_ff;
      end else if (is_oam) begin
         oam_we = (cmd_ff == CMD_WRITE);
         if (cmd_ff == CMD_READ) rd_in = oam_q_ff;
      end else if (is_unused) begin
         if (cmd_ff == CMD_READ) rd_in = 8'hFF;
      end else if (is_port && (cmd_ff == CMD_READ)) begin
         // Port reads; the joypad register is refreshed from the keys first.
         case (p)
            P_JOYP: begin
               joyp_in = {joyp_ff[7:4],
                          4'hF & (joyp_ff[4] ? 4'hF : keys_ff[3:0])
                               & (joyp_ff[5] ? 4'hF : keys_ff[7:4])};
               rd_in = joyp_in;
            end
            P_LCDC:  rd_in = lcdc_ff;
            P_HDMA1: rd_in = hdma1_ff;
            P_HDMA2: rd_in = hdma2_ff;
            P_HDMA3: rd_in = hdma3_ff;
            P_HDMA4: rd_in = hdma4_ff;
            P_BGPI:  rd_in = bgpi_ff;
            P_OBPI:  rd_in = obpi_ff;
            default: rd_in = port_q_ff;
         endcase
      end else if (is_port) begin
         // Port writes with their side effects.
         port_we = 1'b1;
         case (p)
            P_JOYP: begin
               port_we = 1'b0;
               joyp_in = {data_ff[7:4], 4'hF};
            end
            P_LCDC: begin
               port_we = 1'b0;
               lcdt_in = lcdc_ff[7] ^ data_ff[7];
               lcdc_in = data_ff;
            end
            P_HDMA1: begin
               port_we = 1'b0;
               hdma1_in = data_ff;
            end
            P_HDMA2: begin
               port_we = 1'b0;
               hdma2_in = data_ff;
            end
            P_HDMA3: begin
               port_we = 1'b0;
               hdma3_in = data_ff;
            end
            P_HDMA4: begin
               port_we = 1'b0;
               hdma4_in = data_ff;
            end
            P_BGPI: begin
               port_we = 1'b0;
               bgpi_in = data_ff;
               bg_inc_in = data_ff[7];
            end
            P_OBPI: begin
               port_we = 1'b0;
               obpi_in = data_ff;
               ob_inc_in = data_ff[7];
            end
            P_DIV: begin
               port_wdata = 8'h00;
               divr_in = 1'b1;
               timr_in = 1'b1;
            end
            P_TAC: begin
               timr_in = 1'b1;
            end
            P_VBK: begin
               video_bank_in = data_ff[0];
            end
            P_SVBK: begin
               work_bank_in = (data_ff[2:0] == 3'd0) ? 3'd1 : data_ff[2:0];
            end
            P_SB: begin
               port_we = 1'b0;
            end
            P_DMA: begin
               port_we = 1'b0;
               kind_in = DMA_OAM;
               dsrc_in = {data_ff, 8'h00};
               ddst_in = OAM_BASE;
               dlen_in = OAM_DMA_LENGTH;
            end
            P_BGPD: begin
               pal_we  = 1'b1;
               pal_k   = bgpi_ff[5:0];
               pal_idx = PW'({1'b0, pal_k});
               if (bg_inc_ff) bgpi_in = {bgpi_ff[7], 1'b0, pal_k + 6'd1};
            end
            P_OBPD: begin
               pal_we  = 1'b1;
               pal_k   = obpi_ff[5:0];
               pal_idx = PW'({1'b1, pal_k});
               if (ob_inc_ff) obpi_in = {obpi_ff[7], 1'b0, pal_k + 6'd1};
            end
            P_HDMA5: begin
               if (data_ff[7]) begin
                  hb_active_in = 1'b1;
                  hb_src_in    = hdma_src;
                  hb_dst_in    = hdma_dst;
                  hb_blocks_in = hdma_blocks;
                  port_wdata   = {1'b0, data_ff[6:0]};
               end else if (hb_active_ff) begin
                  hb_active_in = 1'b0;
                  port_wdata   = {1'b1, data_ff[6:0]};
               end else begin
                  kind_in    = DMA_GENERAL;
                  dsrc_in    = hdma_src;
                  ddst_in    = hdma_dst;
                  dlen_in    = {hdma_blocks, 4'h0};
                  port_wdata = 8'hFF;
               end
            end
            default: begin
               port_we = 1'b1;
            end
         endcase
      end
   end

   // Request capture at accept.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff      <= req_command;
         addr_ff     <= req_address;
         data_ff     <= req_write_data;
         keys_ff     <= req_key_state;
         vram_idx_ff <= req_vram_idx;
         wram_idx_ff <= req_wram_idx;
         oam_idx_ff  <= req_address[OW-1:0];
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + CW'(1);
      end
   end
   assign status.clear_last = (clr_cnt_ff == CLR_LAST);

   // Video RAM.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         video_mem[clr_cnt_ff[VW-1:0]] <= 8'h00;
      end else if (cmd.exec && vram_we) begin
         video_mem[vram_idx_ff] <= data_ff;
      end
      if (cmd.accept) vram_q_ff <= video_mem[req_vram_idx];
   end

   // Work RAM.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         work_mem[clr_cnt_ff[WW-1:0]] <= 8'h00;
      end else if (cmd.exec && wram_we) begin
         work_mem[wram_idx_ff] <= data_ff;
      end
      if (cmd.accept) wram_q_ff <= work_mem[req_wram_idx];
   end

   // Sprite table; only in-range entries are touched.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if (clr_cnt_ff < CW'(SPRITE_TABLE_BYTES)) sprite_mem[clr_cnt_ff[OW-1:0]] <= 8'h00;
      end else if (cmd.exec && oam_we) begin
         sprite_mem[oam_idx_ff] <= data_ff;
      end
      if (cmd.accept && req_oam) oam_q_ff <= sprite_mem[req_address[OW-1:0]];
   end

   // Port registers and high RAM.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         port_mem[clr_cnt_ff[7:0]] <= 8'h00;
      end else if (cmd.exec && port_we) begin
         port_mem[p] <= port_wdata;
      end
      if (cmd.accept) port_q_ff <= port_mem[req_address[7:0]];
   end

   // Palette RAM, written through the palette data ports.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         palette_mem[clr_cnt_ff[PW-1:0]] <= 8'h00;
      end else if (cmd.exec && pal_we) begin
         palette_mem[pal_idx] <= data_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         video_bank_ff <= 1'b0;
         work_bank_ff  <= 3'd1;
         bg_inc_ff     <= 1'b0;
         ob_inc_ff     <= 1'b0;
         hb_active_ff  <= 1'b0;
         hb_src_ff     <= 16'h0000;
         hb_dst_ff     <= 16'h0000;
         hb_blocks_ff  <= 8'h00;
         joyp_ff       <= 8'h00;
         lcdc_ff       <= 8'h00;
         hdma1_ff      <= 8'h00;
         hdma2_ff      <= 8'h00;
         hdma3_ff      <= 8'h00;
         hdma4_ff      <= 8'h00;
         bgpi_ff       <= 8'h00;
         obpi_ff       <= 8'h00;
      end else if (cmd.exec) begin
         video_bank_ff <= video_bank_in;
         work_bank_ff  <= work_bank_in;
         bg_inc_ff     <= bg_inc_in;
         ob_inc_ff     <= ob_inc_in;
         hb_active_ff  <= hb_active_in;
         hb_src_ff     <= hb_src_in;
         hb_dst_ff     <= hb_dst_in;
         hb_blocks_ff  <= hb_blocks_in;
         joyp_ff       <= joyp_in;
         lcdc_ff       <= lcdc_in;
         hdma1_ff      <= hdma1_in;
         hdma2_ff      <= hdma2_in;
         hdma3_ff      <= hdma3_in;
         hdma4_ff      <= hdma4_in;
         bgpi_ff       <= bgpi_in;
         obpi_ff       <= obpi_in;
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_ff    <= rd_in;
         route_ff <= route_in;
         divr_ff  <= divr_in;
         timr_ff  <= timr_in;
         lcdt_ff  <= lcdt_in;
         kind_ff  <= kind_in;
         dsrc_ff  <= dsrc_in;
         ddst_ff  <= ddst_in;
         dlen_ff  <= dlen_in;
      end
   end

   assign rsp_read_data   = rd_ff;
   assign rsp_route       = route_ff;
   assign rsp_div_reset   = divr_ff;
   assign rsp_timer_reset = timr_ff;
   assign rsp_lcd_toggle  = lcdt_ff;
   assign rsp_dma_kind    = kind_ff;
   assign rsp_dma_source  = dsrc_ff;
   assign rsp_dma_dest    = ddst_ff;
   assign rsp_dma_length  = dlen_ff;

endmodule

// ----- src/handheld_memory_map_unit.sv -----
// Top level of the memory map unit.
// A request is taken when start is high and busy is low; busy then stays high while it executes.
// A new request is not taken until the previous one has executed.
// The response strobe is registered from the execute state and cannot be stalled.
// After reset a clearing pass zeroes all stores; busy is high meanwhile.
module handheld_memory_map_unit #(
   parameter int VIDEO_RAM_BYTES    = hmmu_pkg::VIDEO_RAM_BYTES_DEF,
   parameter int WORK_RAM_BYTES     = hmmu_pkg::WORK_RAM_BYTES_DEF,
   parameter int SPRITE_TABLE_BYTES = hmmu_pkg::SPRITE_TABLE_BYTES_DEF,
   parameter int PALETTE_BYTES      = hmmu_pkg::PALETTE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_key_state,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_route,
   output logic        rsp_div_reset,
   output logic        rsp_timer_reset,
   output logic        rsp_lcd_toggle,
   output logic [1:0]  rsp_dma_kind,
   output logic [15:0] rsp_dma_source,
   output logic [15:0] rsp_dma_dest,
   output logic [11:0] rsp_dma_length
);
   import hmmu_pkg::*;

   hmmu_cmd_type    cmd;
   hmmu_status_type status;

   // Sequencing.
   hmmu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Stores and decode.
   hmmu_datapath #(
      .VIDEO_RAM_BYTES    (VIDEO_RAM_BYTES),
      .WORK_RAM_BYTES     (WORK_RAM_BYTES),
      .SPRITE_TABLE_BYTES (SPRITE_TABLE_BYTES),
      .PALETTE_BYTES      (PALETTE_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_key_state   (req_key_state),
      .rsp_read_data   (rsp_read_data),
      .rsp_route       (rsp_route),
      .rsp_div_reset   (rsp_div_reset),
      .rsp_timer_reset (rsp_timer_reset),
      .rsp_lcd_toggle  (rsp_lcd_toggle),
      .rsp_dma_kind    (rsp_dma_kind),
      .rsp_dma_source  (rsp_dma_source),
      .rsp_dma_dest    (rsp_dma_dest),
      .rsp_dma_length  (rsp_dma_length)
   );

endmodule

// ----- src/hmmu_checker.sv -----
// Port-level checker of the memory map unit and its bind.
`include "handheld_memory_map_unit_macros.svh"

module hmmu_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [7:0]  rsp_read_data,
   input logic [1:0]  rsp_route,
   input logic [1:0]  rsp_dma_kind,
   input logic [15:0] rsp_dma_source,
   input logic [11:0] rsp_dma_length
);
   import hmmu_pkg::*;

   // An accepted request holds the unit busy in the next cycle.
   `HMMU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // Responses never come back to back.
   `HMMU_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
   // Forwarded requests return no local data.
   `HMMU_ASSERT_IMPLY(a_fwd_zero, clock, reset, rsp_strobe && (rsp_route != ROUTE_LOCAL),
                      (rsp_read_data == 8'h00) && (rsp_dma_kind == DMA_NONE))
   // No copy request means an empty copy description.
   `HMMU_ASSERT_IMPLY(a_no_copy, clock, reset, rsp_strobe && (rsp_dma_kind == DMA_NONE),
                      (rsp_dma_source == 16'h0000) && (rsp_dma_length == 12'h000))

endmodule

bind handheld_memory_map_unit hmmu_checker u_hmmu_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_read_data  (rsp_read_data),
   .rsp_route      (rsp_route),
   .rsp_dma_kind   (rsp_dma_kind),
   .rsp_dma_source (rsp_dma_source),
   .rsp_dma_length (rsp_dma_length)
);

// ----- verif/hmmu_checker.sv -----
// Checker for the memory map unit: watches requests and responses, predicts and compares.
`timescale 1ns / 100ps

module hmmu_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_key_state,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_read_data,
   input  logic [1:0]  rsp_route,
   input  logic        rsp_div_reset,
   input  logic        rsp_timer_reset,
   input  logic        rsp_lcd_toggle,
   input  logic [1:0]  rsp_dma_kind,
   input  logic [15:0] rsp_dma_source,
   input  logic [15:0] rsp_dma_dest,
   input  logic [11:0] rsp_dma_length,
   output int          error_count,
   output int          pending_count
);
   import hmmu_pkg::*;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  route;
      logic        div_reset;
      logic        timer_reset;
      logic        lcd_toggle;
      logic [1:0]  dma_kind;
      logic [15:0] dma_source;
      logic [15:0] dma_dest;
      logic [11:0] dma_length;
   } access_result_type;

   // Shadow copy of the block's stores and bank state.
   logic [7:0]  vram_mirror [VIDEO_RAM_BYTES_DEF];
   logic [7:0]  wram_mirror [WORK_RAM_BYTES_DEF];
   logic [7:0]  oam_mirror [SPRITE_TABLE_BYTES_DEF];
   logic [7:0]  port_mirror [256];
   logic [7:0]  palette_mirror [PALETTE_BYTES_DEF];
   logic        video_bank_mirror;
   logic [2:0]  wram_bank;
   logic [1:0]  pal_autoinc;
   logic        hblank_armed;
   access_result_type expected_responses [$];

   task automatic clear_mirror();
      foreach (vram_mirror[i]) vram_mirror[i] = '0;
      foreach (wram_mirror[i]) wram_mirror[i] = '0;
      foreach (oam_mirror[i]) oam_mirror[i] = '0;
      foreach (port_mirror[i]) port_mirror[i] = '0;
      foreach (palette_mirror[i]) palette_mirror[i] = '0;
      video_bank_mirror = 1'b0;
      wram_bank = 3'd1;
      pal_autoinc = 2'b00;
      hblank_armed = 1'b0;
   endtask

   // Palette data port: write at the indexed slot, then advance the index if enabled.
   function automatic void palette_store(input int which, input logic [7:0] idx_port,
                                         input logic [7:0] data);
      logic [7:0] idx;
      idx = port_mirror[idx_port];
      palette_mirror[(which != 0 ? 64 : 0) + int'(idx[5:0])] = data;
      if (pal_autoinc[which])
         port_mirror[idx_port] = {idx[7], 1'b0, idx[5:0] + 6'd1};
   endfunction

   // Decode one bus access against the shadow state and return its response.
   function automatic access_result_type decode_access(input logic wr, input logic [15:0] addr,
                                                       input logic [7:0] wdata,
                                                       input logic [7:0] keys);
      access_result_type r;
      logic [7:0]  data;
      logic [7:0]  p;
      logic [7:0]  low;
      logic        keep;
      logic [15:0] src;
      logic [15:0] dst;
      logic [7:0]  blocks;
      int          idx;
      r = '0;
      data = wdata;
      if (addr <= 16'h7FFF || (addr >= 16'hA000 && addr <= 16'hBFFF)) begin
         r.route = ROUTE_CART;
      end else if (addr <= 16'h9FFF) begin
         idx = int'({video_bank_mirror, addr[12:0]});
         if (wr) vram_mirror[idx] = data; else r.read_data = vram_mirror[idx];
      end else if (addr <= 16'hFDFF) begin
         // Echo space folds onto C000-DFFF; the upper 4K follows the switched bank.
         if (addr[12] == 1'b0) idx = int'(addr[11:0]);
         else idx = int'({wram_bank, addr[11:0]});
         if (wr) wram_mirror[idx] = data; else r.read_data = wram_mirror[idx];
      end else if (addr <= 16'hFE9F) begin
         idx = int'(addr - 16'hFE00);
         if (wr) oam_mirror[idx] = data; else r.read_data = oam_mirror[idx];
      end else if (addr <= 16'hFEFF) begin
         if (!wr) r.read_data = 8'hFF;
      end else if (addr >= 16'hFF10 && addr <= 16'hFF3F) begin
         r.route = ROUTE_SOUND;
      end else begin
         p = addr[7:0];
         if (!wr) begin
            // Joypad read merges the selected key groups and keeps the result.
            if (p == P_JOYP) begin
               low = 8'h0F;
               if (!port_mirror[P_JOYP][4]) low &= {4'h0, keys[3:0]};
               if (!port_mirror[P_JOYP][5]) low &= {4'h0, keys[7:4]};
               port_mirror[P_JOYP] = (port_mirror[P_JOYP] & 8'hF0) | low;
            end
            r.read_data = port_mirror[p];
         end else begin
            keep = 1'b1;
            case (p)
               P_DIV: begin
                  data = 8'h00;
                  r.div_reset = 1'b1;
                  r.timer_reset = 1'b1;
               end
               P_TAC: r.timer_reset = 1'b1;
               P_JOYP: data = (data & 8'hF0) | 8'h0F;
               P_VBK: video_bank_mirror = data[0];
               P_SVBK: wram_bank = (data[2:0] == 3'd0) ? 3'd1 : data[2:0];
               P_SB: keep = 1'b0;
               P_DMA: begin
                  r.dma_kind = DMA_OAM;
                  r.dma_source = {data, 8'h00};
                  r.dma_dest = OAM_BASE;
                  r.dma_length = OAM_DMA_LENGTH;
                  keep = 1'b0;
               end
               P_BGPI: pal_autoinc[0] = data[7];
               P_BGPD: palette_store(0, P_BGPI, data);
               P_OBPI: pal_autoinc[1] = data[7];
               P_OBPD: palette_store(1, P_OBPI, data);
               P_HDMA5: begin
                  src = {port_mirror[P_HDMA1], port_mirror[P_HDMA2]} & 16'hFFF0;
                  dst = ({port_mirror[P_HDMA3], port_mirror[P_HDMA4]} & 16'h1FF0) | 16'h8000;
                  blocks = {1'b0, data[6:0]} + 8'd1;
                  if (data[7]) begin
                     hblank_armed = 1'b1;
                     data = data & 8'h7F;
                  end else if (hblank_armed) begin
                     hblank_armed = 1'b0;
                     data = data | 8'h80;
                  end else begin
                     r.dma_kind = DMA_GENERAL;
                     r.dma_source = src;
                     r.dma_dest = dst;
                     r.dma_length = {blocks, 4'h0};
                     data = 8'hFF;
                  end
               end
               P_LCDC: r.lcd_toggle = port_mirror[P_LCDC][7] ^ data[7];
               default: ;
            endcase
            if (keep) port_mirror[p] = data;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("hmmu_scoreboard: %s mismatch at %0t: got %h, expected %h",
               what, $time, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
      clear_mirror();
   end

   // Predict on each accepted request; compare each response with the oldest prediction.
   always @(posedge clock) begin
      access_result_type exp_r;
      if (reset) begin
         clear_mirror();
         expected_responses.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 16'h0, 16'h0);
            end else begin
               exp_r = expected_responses.pop_front();
               if (rsp_read_data !== exp_r.read_data)
                  report_mismatch("read_data", 16'(rsp_read_data), 16'(exp_r.read_data));
               if (rsp_route !== exp_r.route)
                  report_mismatch("route", 16'(rsp_route), 16'(exp_r.route));
               if (rsp_div_reset !== exp_r.div_reset)
                  report_mismatch("div_reset", 16'(rsp_div_reset), 16'(exp_r.div_reset));
               if (rsp_timer_reset !== exp_r.timer_reset)
                  report_mismatch("timer_reset", 16'(rsp_timer_reset),
                                  16'(exp_r.timer_reset));
               if (rsp_lcd_toggle !== exp_r.lcd_toggle)
                  report_mismatch("lcd_toggle", 16'(rsp_lcd_toggle), 16'(exp_r.lcd_toggle));
               if (rsp_dma_kind !== exp_r.dma_kind)
                  report_mismatch("dma_kind", 16'(rsp_dma_kind), 16'(exp_r.dma_kind));
               if (rsp_dma_source !== exp_r.dma_source)
                  report_mismatch("dma_source", rsp_dma_source, exp_r.dma_source);
               if (rsp_dma_dest !== exp_r.dma_dest)
                  report_mismatch("dma_dest", rsp_dma_dest, exp_r.dma_dest);
               if (rsp_dma_length !== exp_r.dma_length)
                  report_mismatch("dma_length", 16'(rsp_dma_length), 16'(exp_r.dma_length));
            end
         end
         if (start && !busy)
            expected_responses.push_back(decode_access(req_command, req_address,
                                                       req_write_data, req_key_state));
      end
      pending_count = expected_responses.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: clock, reset, access stimulus and the final verdict.
`timescale 1ns / 100ps

module tb_top;
   import hmmu_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_command;
   logic [15:0] req_address;
   logic [7:0]  req_write_data;
   logic [7:0]  req_key_state;
   logic        rsp_strobe;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_route;
   logic        rsp_div_reset;
   logic        rsp_timer_reset;
   logic        rsp_lcd_toggle;
   logic [1:0]  rsp_dma_kind;
   logic [15:0] rsp_dma_source;
   logic [15:0] rsp_dma_dest;
   logic [11:0] rsp_dma_length;
   int          error_count;
   int          pending_count;
   int          cycle_count;
   int          gap_percent;

   localparam int CYCLE_LIMIT = 400000;

   handheld_memory_map_unit dut (.*);
   hmmu_scoreboard scoreboard_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Present one request and hold it until busy is seen low; start stays high after.
   task automatic send_access(input logic wr, input logic [15:0] addr,
                              input logic [7:0] data, input logic [7:0] keys);
      while (gap_percent > 0 && $urandom_range(99, 0) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= wr;
      req_address <= addr;
      req_write_data <= data;
      req_key_state <= keys;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_address();
      logic [15:0] ports [13];
      ports = '{16'hFF00, 16'hFF04, 16'hFF07, 16'hFF40, 16'hFF46, 16'hFF4D, 16'hFF4F,
                16'hFF55, 16'hFF68, 16'hFF69, 16'hFF6A, 16'hFF6B, 16'hFF70};
      case ($urandom_range(9, 0))
         0: return 16'($urandom_range(16'hFFFF, 0));
         1: return 16'($urandom_range(16'h9FFF, 16'h8000));
         2, 3: return 16'($urandom_range(16'hDFFF, 16'hC000));
         4: return 16'($urandom_range(16'hFDFF, 16'hE000));
         5: return 16'($urandom_range(16'hFEFF, 16'hFE00));
         6: return 16'($urandom_range(16'hFFFF, 16'hFF00));
         7: return {8'hFF, 4'h5, 4'($urandom_range(5, 1))};
         default: return ports[$urandom_range(12, 0)];
      endcase
   endfunction

   // Random traffic: random reads and writes, some read back, with port side effects.
   task automatic random_phase(input int count);
      logic [15:0] a;
      repeat (count) begin
         a = pick_address();
         send_access(1'($urandom_range(1, 0)), a, 8'($urandom_range(255, 0)),
                     8'($urandom_range(255, 0)));
         if ($urandom_range(3, 0) == 0)
            send_access(CMD_READ, a, 8'($urandom_range(255, 0)),
                        8'($urandom_range(255, 0)));
      end
   endtask

   initial begin
      cycle_count = 0;
      gap_percent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_READ;
      req_address = '0;
      req_write_data = '0;
      req_key_state = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of the map and most special ports.
      send_access(CMD_READ, 16'h0000, 8'h00, 8'hFF);
      send_access(CMD_WRITE, 16'hBFFF, 8'hFF, 8'h00);
      send_access(CMD_WRITE, 16'hFF10, 8'h5A, 8'h00);
      send_access(CMD_READ, 16'hFF3F, 8'h00, 8'h00);
      send_access(CMD_WRITE, 16'hFF4F, 8'h01, 8'h00);
      send_access(CMD_WRITE, 16'h9FFF, 8'hA5, 8'h00);
      send_access(CMD_READ, 16'h9FFF, 8'h00, 8'h00);
      send_access(CMD_WRITE, 16'hFF70, 8'h00, 8'h00);
      send_access(CMD_WRITE, 16'hFDFF, 8'h3C, 8'h00);
      send_access(CMD_READ, 16'hDDFF, 8'h00, 8'h00);
      send_access(CMD_WRITE, 16'hFE9F, 8'h77, 8'h00);
      send_access(CMD_READ, 16'hFEA0, 8'h00, 8'h00);
      send_access(CMD_WRITE, 16'hFF00, 8'h20, 8'h00);
      send_access(CMD_READ, 16'hFF00, 8'h00, 8'hE7);
      send_access(CMD_WRITE, 16'hFF04, 8'h99, 8'h00);
      send_access(CMD_WRITE, 16'hFF07, 8'h05, 8'h00);
      send_access(CMD_WRITE, 16'hFF40, 8'h80, 8'h00);
      send_access(CMD_WRITE, 16'hFF46, 8'hC1, 8'h00);
      send_access(CMD_WRITE, 16'hFF4D, 8'h01, 8'h00);
      send_access(CMD_WRITE, 16'hFF01, 8'h12, 8'h00);
      send_access(CMD_WRITE, 16'hFF68, 8'hBF, 8'h00);
      send_access(CMD_WRITE, 16'hFF69, 8'h11, 8'h00);
      send_access(CMD_WRITE, 16'hFF55, 8'h85, 8'h00);
      send_access(CMD_WRITE, 16'hFF55, 8'h00, 8'h00);
      send_access(CMD_WRITE, 16'hFF55, 8'h7F, 8'h00);
      start <= 1'b0;

      // Pause until the pipeline drains, then random traffic under three idle mixes.
      while (pending_count != 0) @(posedge clock);
      gap_percent = 24;
      random_phase(180);
      gap_percent = 84;
      random_phase(180);
      gap_percent = 0;
      random_phase(200);
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- handheld_memory_map_unit.f -----
+incdir+src
src/hmmu_pkg.sv
src/hmmu_ctrl.sv
src/hmmu_datapath.sv
src/handheld_memory_map_unit.sv
src/hmmu_checker.sv
verif/hmmu_checker.sv
verif/tb_top.sv
